// ===== rtl/ccl_pkg.sv =====
package ccl_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MaxLabels = 16384;

  localparam int LabelW = 14;
  localparam int AddrW  = 16;
  localparam int SideW  = 9;
  localparam int PosW   = 8;
  localparam int NfW    = 15;
  localparam int ProdW  = 2 * SideW;
  localparam int PixW   = 8;
  localparam int PaddrW = 3;
  localparam int DataW  = 32;

  localparam int FifoDepth = 4;

  localparam logic [SideW-1:0] MinSide     = SideW'(3);
  localparam logic [SideW-1:0] MaxWidthV   = SideW'(MaxWidth);
  localparam logic [SideW-1:0] MaxHeightV  = SideW'(MaxHeight);
  localparam logic [SideW-1:0] SideReset   = SideW'(256);
  localparam logic [NfW-1:0]   FirstLabel  = NfW'(2);
  localparam logic [NfW-1:0]   LabelLimit  = NfW'(MaxLabels);

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic RegImgWidth  = 1'b0;
  localparam logic RegImgHeight = 1'b1;

  typedef enum logic [1:0] {
    OP_BG,
    OP_OBJ,
    OP_READ
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic              start;
    logic              last;
    logic              addr_ok;
    logic [AddrW-1:0]  idx;
    logic [SideW-1:0]  width;
  } ccl_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENTRY,
    S_NB,
    S_DECIDE,
    S_MRG_A,
    S_MRG_B,
    S_MRG_C,
    S_SW_RD,
    S_SW_CHK,
    S_WRITE,
    S_POST,
    S_FIN_RD,
    S_FIN_CHK,
    S_FIN_IND,
    S_FIN_END,
    S_RD_LS,
    S_RD_EQ,
    S_EMIT
  } back_state_e;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v,
                                                  input logic [SideW-1:0] hi);
    logic [SideW-1:0] r;
    r = v;
    if (v < MinSide) begin
      r = MinSide;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ccl_ram.sv =====
module ccl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ccl_fifo.sv =====
module ccl_fifo import ccl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  ccl_op_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output ccl_op_t data_o,
  output logic    empty_o
);

  localparam int PtrW = $clog2(FifoDepth);

  ccl_op_t          mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/ccl_front.sv =====
module ccl_front import ccl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [PixW-1:0]   pixel_i,
  input  logic [AddrW-1:0]  address_i,
  output logic              push_o,
  output ccl_op_t           op_o,
  input  logic              full_i
);

  logic [SideW-1:0] img_w_q, img_h_q;
  logic [SideW-1:0] fw_q, fh_q;
  logic [PosW-1:0]  col_q, row_q;
  logic [AddrW-1:0] idx_q;
  logic [ProdW-1:0] frame_n;
  logic             accept, is_pix, start, col_end, row_end, border;
  logic [SideW-1:0] w_eff, h_eff;

  assign pready = 1'b1;
  assign prdata = {(DataW-SideW)'(0), (paddr[2] == RegImgHeight) ? img_h_q : img_w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= SideReset;
      img_h_q <= SideReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegImgHeight) begin
        img_h_q <= pwdata[SideW-1:0];
      end else begin
        img_w_q <= pwdata[SideW-1:0];
      end
    end
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_pix     = (command_i == CmdPixel);
  assign start      = is_pix && (col_q == '0) && (row_q == '0);
  assign w_eff      = start ? clamp_side(img_w_q, MaxWidthV) : fw_q;
  assign h_eff      = start ? clamp_side(img_h_q, MaxHeightV) : fh_q;
  assign col_end    = (({1'b0, col_q} + SideW'(1)) == w_eff);
  assign row_end    = (({1'b0, row_q} + SideW'(1)) == h_eff);
  assign border     = (col_q == '0) || (row_q == '0) || col_end || row_end;
  assign frame_n    = fw_q * fh_q;

  always_comb begin
    op_o.start   = start;
    op_o.last    = is_pix && col_end && row_end;
    op_o.addr_ok = ({(ProdW-AddrW)'(0), address_i} < frame_n);
    op_o.idx     = is_pix ? idx_q : address_i;
    op_o.width   = w_eff;
    if (!is_pix) begin
      op_o.kind = OP_READ;
    end else if ((pixel_i != '0) && !border) begin
      op_o.kind = OP_OBJ;
    end else begin
      op_o.kind = OP_BG;
    end
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= '0;
      fh_q  <= '0;
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else if (accept && is_pix) begin
      if (start) begin
        fw_q <= w_eff;
        fh_q <= h_eff;
      end
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + PosW'(1);
      end else begin
        col_q <= col_q + PosW'(1);
      end
      idx_q <= (col_end && row_end) ? '0 : idx_q + AddrW'(1);
    end
  end

endmodule

// ===== rtl/ccl_back.sv =====
module ccl_back import ccl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ccl_op_t           op_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [LabelW-1:0] label_o,
  output logic [LabelW-1:0] component_count_o,
  output logic              frame_done_o,
  output logic              overflow_o
);

  localparam int EqAW = $clog2(MaxLabels);

  back_state_e       state_q, state_d;
  ccl_op_t           op_q, op_d;
  logic [LabelW-1:0] nb_q [4];
  logic [LabelW-1:0] nb_d [4];
  logic [1:0]        cnt_q, cnt_d, nb_sel;
  logic [LabelW-1:0] lab_q, lab_d, ma_q, ma_d, mb_q, mb_d, ra_q, ra_d;
  logic [LabelW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [NfW-1:0]    ptr_q, ptr_d, k_q, k_d, nf_q, nf_d, ptr_inc;
  logic              done_q, done_d, ovf_q, ovf_d;
  logic [LabelW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [LabelW-1:0] out_label_q, out_label_d, out_count_q, out_count_d;
  logic              out_done_q, out_done_d, out_ovf_q, out_ovf_d;

  logic              ls_we, eq_we;
  logic [AddrW-1:0]  ls_waddr, ls_raddr, nb_addr, w_ext;
  logic [LabelW-1:0] ls_wdata, ls_rdata, eq_wdata, eq_rdata;
  logic [EqAW-1:0]   eq_waddr, eq_raddr;

  ccl_ram #(.Width(LabelW), .Depth(MaxWidth * MaxHeight)) u_ls_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  ccl_ram #(.Width(LabelW), .Depth(MaxLabels)) u_eq_ram (
    .clk_i   (clk_i),
    .we_i    (eq_we),
    .waddr_i (eq_waddr),
    .wdata_i (eq_wdata),
    .raddr_i (eq_raddr),
    .rdata_o (eq_rdata)
  );

  // neighbor order: left, up-left, up, up-right
  assign w_ext = {(AddrW-SideW)'(0), op_q.width};
  always_comb begin
    case (nb_sel)
      2'd0:    nb_addr = op_q.idx - AddrW'(1);
      2'd1:    nb_addr = op_q.idx - AddrW'(1) - w_ext;
      2'd2:    nb_addr = op_q.idx - w_ext;
      default: nb_addr = op_q.idx + AddrW'(1) - w_ext;
    endcase
  end

  assign ptr_inc = ptr_q + NfW'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    nb_d        = nb_q;
    cnt_d       = cnt_q;
    lab_d       = lab_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    ra_d        = ra_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    nf_d        = nf_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_label_d = out_label_q;
    out_count_d = out_count_q;
    out_done_d  = out_done_q;
    out_ovf_d   = out_ovf_q;
    pop_o       = 1'b0;
    nb_sel      = cnt_q + 2'd1;
    ls_we       = 1'b0;
    ls_waddr    = op_q.idx;
    ls_wdata    = lab_q;
    ls_raddr    = nb_addr;
    eq_we       = 1'b0;
    eq_waddr    = ptr_q[EqAW-1:0];
    eq_wdata    = lo_q;
    eq_raddr    = ptr_q[EqAW-1:0];

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          op_d    = op_i;
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (op_q.start) begin
          // entries above entry 1 become identity as labels get allocated
          nf_d     = FirstLabel;
          done_d   = 1'b0;
          count_d  = '0;
          ovf_d    = 1'b0;
          eq_we    = 1'b1;
          eq_waddr = EqAW'(1);
          eq_wdata = LabelW'(1);
        end
        case (op_q.kind)
          OP_OBJ: begin
            nb_sel  = 2'd0;
            cnt_d   = 2'd0;
            state_d = S_NB;
          end
          OP_READ: begin
            lab_d    = '0;
            ls_raddr = op_q.idx;
            state_d  = (done_q && op_q.addr_ok) ? S_RD_LS : S_EMIT;
          end
          default: begin
            lab_d    = '0;
            ls_we    = 1'b1;
            ls_wdata = '0;
            state_d  = S_POST;
          end
        endcase
      end
      S_NB: begin
        nb_d[cnt_q] = ls_rdata;
        if (cnt_q == 2'd3) begin
          state_d = S_DECIDE;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      S_DECIDE: begin
        state_d = S_WRITE;
        if (nb_q[2] != '0) begin
          lab_d = nb_q[2];
        end else if (nb_q[0] != '0) begin
          lab_d = nb_q[0];
          if (nb_q[3] != '0) begin
            ma_d    = nb_q[0];
            mb_d    = nb_q[3];
            state_d = S_MRG_A;
          end
        end else if (nb_q[1] != '0) begin
          lab_d = nb_q[1];
          if (nb_q[3] != '0) begin
            ma_d    = nb_q[1];
            mb_d    = nb_q[3];
            state_d = S_MRG_A;
          end
        end else if (nb_q[3] != '0) begin
          lab_d = nb_q[3];
        end else if (nf_q < LabelLimit) begin
          lab_d    = nf_q[LabelW-1:0];
          eq_we    = 1'b1;
          eq_waddr = nf_q[EqAW-1:0];
          eq_wdata = nf_q[LabelW-1:0];
          nf_d     = nf_q + NfW'(1);
        end else begin
          lab_d = '0;
          ovf_d = 1'b1;
        end
      end
      S_MRG_A: begin
        eq_raddr = ma_q;
        state_d  = S_MRG_B;
      end
      S_MRG_B: begin
        ra_d     = eq_rdata;
        eq_raddr = mb_q;
        state_d  = S_MRG_C;
      end
      S_MRG_C: begin
        if (ra_q == eq_rdata) begin
          state_d = S_WRITE;
        end else begin
          lo_d    = (ra_q < eq_rdata) ? ra_q : eq_rdata;
          hi_d    = (ra_q < eq_rdata) ? eq_rdata : ra_q;
          ptr_d   = NfW'(1);
          state_d = S_SW_RD;
        end
      end
      S_SW_RD: begin
        state_d = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (eq_rdata == hi_q) begin
          eq_we = 1'b1;
        end
        ptr_d   = ptr_inc;
        state_d = (ptr_inc == nf_q) ? S_WRITE : S_SW_RD;
      end
      S_WRITE: begin
        ls_we   = 1'b1;
        state_d = S_POST;
      end
      S_POST: begin
        if (op_q.last) begin
          ptr_d   = NfW'(1);
          k_d     = '0;
          state_d = S_FIN_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_FIN_RD: begin
        state_d = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        // a root gets the next consecutive number, others follow their root
        if (eq_rdata == ptr_q[LabelW-1:0]) begin
          eq_we    = 1'b1;
          eq_wdata = k_q[LabelW-1:0];
          k_d      = k_q + NfW'(1);
          ptr_d    = ptr_inc;
          state_d  = (ptr_inc == nf_q) ? S_FIN_END : S_FIN_RD;
        end else begin
          eq_raddr = eq_rdata;
          state_d  = S_FIN_IND;
        end
      end
      S_FIN_IND: begin
        eq_we    = 1'b1;
        eq_wdata = eq_rdata;
        ptr_d    = ptr_inc;
        state_d  = (ptr_inc == nf_q) ? S_FIN_END : S_FIN_RD;
      end
      S_FIN_END: begin
        count_d = LabelW'(k_q - NfW'(1));
        done_d  = 1'b1;
        state_d = S_EMIT;
      end
      S_RD_LS: begin
        if (ls_rdata == '0) begin
          lab_d   = '0;
          state_d = S_EMIT;
        end else begin
          eq_raddr = ls_rdata;
          state_d  = S_RD_EQ;
        end
      end
      S_RD_EQ: begin
        lab_d   = eq_rdata;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_label_d = (op_q.kind == OP_READ) ? lab_q : '0;
          out_count_d = count_q;
          out_done_d  = done_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= FirstLabel;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nf_q        <= nf_d;
      done_q      <= done_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    nb_q        <= nb_d;
    cnt_q       <= cnt_d;
    lab_q       <= lab_d;
    ma_q        <= ma_d;
    mb_q        <= mb_d;
    ra_q        <= ra_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    ptr_q       <= ptr_d;
    k_q         <= k_d;
    out_label_q <= out_label_d;
    out_count_q <= out_count_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign label_o           = out_label_q;
  assign component_count_o = out_count_q;
  assign frame_done_o      = out_done_q;
  assign overflow_o        = out_ovf_q;

endmodule

// ===== rtl/connected_component_labeler_top.sv =====
// Connected component labeler, 8-connectivity, two passes over an internal
// label store. Input items carry command_i (0 = raster pixel, 1 = read),
// pixel_i and address_i; each item yields exactly one result item with
// label_o, component_count_o, frame_done_o and overflow_o.
// Frame size is set through the APB registers img_width (0x0) and
// img_height (0x4) and is latched at the first pixel of a frame.
// The front classifies each item in the cycle it is accepted and queues it
// (4 entries); the back works on one item at a time.
// A background or border pixel writes label zero; an interior object pixel
// reads its four neighbours one after another and then decides, plus a scan
// over the equivalence entries in use when a merge is needed; reads of a
// finished frame look up the label store and then the equivalence table. The
// last pixel of a frame adds a renumbering pass over the equivalence entries
// in use. The single read ports of the two memories make these steps serial.
// Reset empties the queue and the output register; no clearing pass is
// run. A stalled result holds in the output register while the front
// keeps taking items until the queue is full.
module connected_component_labeler_top import ccl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [PixW-1:0]   pixel_i,
  input  logic [AddrW-1:0]  address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LabelW-1:0] label_o,
  output logic [LabelW-1:0] component_count_o,
  output logic              frame_done_o,
  output logic              overflow_o
);

  ccl_op_t push_op, pop_op;
  logic    push, full, pop, empty;

  ccl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .pixel_i    (pixel_i),
    .address_i  (address_i),
    .push_o     (push),
    .op_o       (push_op),
    .full_i     (full)
  );

  ccl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_op),
    .empty_o (empty)
  );

  ccl_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .op_i              (pop_op),
    .pop_o             (pop),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .label_o           (label_o),
    .component_count_o (component_count_o),
    .frame_done_o      (frame_done_o),
    .overflow_o        (overflow_o)
  );

endmodule

// ===== rtl/ccl_checker.sv =====
module ccl_checker import ccl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [LabelW-1:0] label_o,
  input logic [LabelW-1:0] component_count_o,
  input logic              frame_done_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(label_o))
    else $error("result changed while stalled");

  // nonzero labels only come from a finished frame
  a_label_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (label_o != '0) |-> frame_done_o)
    else $error("label reported before frame done");

  // the count is only latched together with frame done
  a_count_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> (component_count_o == '0))
    else $error("count reported before frame done");

endmodule

bind connected_component_labeler_top ccl_checker u_ccl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .label_o           (label_o),
  .component_count_o (component_count_o),
  .frame_done_o      (frame_done_o)
);

// ===== verif/tb_top.sv =====
module tb_top;
  import ccl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 40000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [LabelW-1:0] count;
    logic              done;
    logic              ovf;
  } label_res_t;

  typedef struct {
    logic              cmd;
    logic [PixW-1:0]   pix;
    logic [AddrW-1:0]  addr;
    bit                typed;
    label_res_t        res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = CmdPixel;
  logic [PixW-1:0]   pixel_i = '0;
  logic [AddrW-1:0]  address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [LabelW-1:0] label_o, component_count_o;
  logic              frame_done_o, overflow_o;

  connected_component_labeler_top dut (.*);

  always #2 clk_i = ~clk_i;

  // labeler state mirror
  int lab_mem [MaxWidth*MaxHeight];
  int eq_mem [MaxLabels];
  int next_lab, col_pos, row_pos, cnt_f;
  bit done_f, ovf_f;
  int reg_w, reg_h, fw, fh;

  label_res_t label_q[$];
  int errors, items_sent, results_seen, frames_done, reads_sent;
  bit quiet, hold_req;

  function automatic int clamp_sz(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eq_at(int i);
    return (i < MaxLabels) ? eq_mem[i] : 0;
  endfunction

  function automatic void join_roots(int a, int b);
    int ra, rb, lo, hi;
    ra = eq_at(a);
    rb = eq_at(b);
    lo = ra < rb ? ra : rb;
    hi = ra < rb ? rb : ra;
    for (int i = 1; i < next_lab && i < MaxLabels; i++)
      if (eq_mem[i] == hi) eq_mem[i] = lo;
  endfunction

  function automatic int provisional_label(int pix);
    int idx, c1, c2, c3, c4;
    idx = row_pos * fw + col_pos;
    if (pix == 0 || col_pos == 0 || row_pos == 0 || col_pos + 1 >= fw || row_pos + 1 >= fh)
      return 0;
    c1 = lab_mem[idx-1];
    c2 = lab_mem[idx-1-fw];
    c3 = lab_mem[idx-fw];
    c4 = lab_mem[idx+1-fw];
    if (c3 != 0) return c3;
    if (c1 != 0) begin
      if (c4 != 0) join_roots(c1, c4);
      return c1;
    end
    if (c2 != 0) begin
      if (c4 != 0) join_roots(c2, c4);
      return c2;
    end
    if (c4 != 0) return c4;
    if (next_lab < MaxLabels) begin
      next_lab++;
      return next_lab - 1;
    end
    ovf_f = 1'b1;
    return 0;
  endfunction

  function automatic label_res_t predict_label(logic cmd, int pix, int addr);
    label_res_t r;
    int lab, k;
    pix = pix & 'hFF;
    addr = addr & 'hFFFF;
    lab = 0;
    if (cmd == CmdPixel) begin
      if (col_pos == 0 && row_pos == 0) begin
        fw = clamp_sz(reg_w, MaxWidth);
        fh = clamp_sz(reg_h, MaxHeight);
        for (int i = 0; i < MaxLabels; i++) eq_mem[i] = i;
        next_lab = 2;
        done_f = 1'b0;
        cnt_f = 0;
        ovf_f = 1'b0;
      end
      lab_mem[row_pos*fw + col_pos] = provisional_label(pix);
      col_pos++;
      if (col_pos >= fw) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= fh) begin
          row_pos = 0;
          // renumber roots consecutively
          k = 0;
          for (int i = 1; i < next_lab && i < MaxLabels; i++) begin
            if (eq_mem[i] == i) begin
              eq_mem[i] = k;
              k++;
            end else begin
              eq_mem[i] = eq_at(eq_mem[i]);
            end
          end
          cnt_f = (k - 1) & 16'h3FFF;
          done_f = 1'b1;
          frames_done++;
        end
      end
    end else if (done_f && addr < fw * fh) begin
      lab = lab_mem[addr] != 0 ? eq_at(lab_mem[addr]) : 0;
    end
    r.label = LabelW'(lab);
    r.count = LabelW'(cnt_f);
    r.done = done_f;
    r.ovf = ovf_f;
    return r;
  endfunction

  task automatic apb_write(logic idx, int val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PaddrW'(4 * idx);
    pwdata <= DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegImgWidth) reg_w = val & 9'h1FF;
    else reg_h = val & 9'h1FF;
  endtask

  task automatic set_frame(int w, int h);
    wait (label_q.size() == 0);
    repeat (20) @(negedge clk_i);
    apb_write(RegImgWidth, w);
    apb_write(RegImgHeight, h);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(logic cmd, int pix, int addr, bit typed, label_res_t want);
    label_res_t p;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    p = predict_label(cmd, pix, addr);
    label_q.push_back(typed ? want : p);
    command_i <= cmd;
    pixel_i <= PixW'(pix);
    address_i <= AddrW'(addr);
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
    if (cmd == CmdRead) reads_sent++;
  endtask

  task automatic run_frame(int w, int h, int hold_at);
    int density, pix, n;
    label_res_t z;
    z = '0;
    set_frame(w, h);
    density = $urandom_range(25, 75);
    // size the frame from the registers just written
    n = clamp_sz(w & 'h1FF, MaxWidth) * clamp_sz(h & 'h1FF, MaxHeight);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      // stray reads mid-frame see an unfinished frame
      if ($urandom_range(0, 19) == 0) send_item(CmdRead, $urandom, $urandom, 0, z);
      pix = ($urandom_range(0, 99) < density) ? $urandom_range(1, 255) : 0;
      send_item(CmdPixel, pix, $urandom, 0, z);
    end
    repeat ($urandom_range(10, 25)) begin
      if ($urandom_range(0, 4) == 0) send_item(CmdRead, $urandom, $urandom, 0, z);
      else send_item(CmdRead, $urandom, $urandom_range(0, n - 1), 0, z);
    end
    in_valid_i <= 1'b0;
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(logic cmd, int pix, int addr, bit typed,
                                   int lab, int cnt, bit dn);
    stim_row_t s;
    s.cmd = cmd;
    s.pix = PixW'(pix);
    s.addr = AddrW'(addr);
    s.typed = typed;
    s.res.label = LabelW'(lab);
    s.res.count = LabelW'(cnt);
    s.res.done = dn;
    s.res.ovf = 1'b0;
    return s;
  endfunction

  // output monitor
  always @(posedge clk_i) begin
    label_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (label_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = label_q.pop_front();
        if (label_o !== e.label) begin
          $error("label exp %0d got %0d", e.label, label_o);
          errors++;
        end
        if (component_count_o !== e.count) begin
          $error("component_count exp %0d got %0d", e.count, component_count_o);
          errors++;
        end
        if (frame_done_o !== e.done) begin
          $error("frame_done exp %0d got %0d", e.done, frame_done_o);
          errors++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on handshake progress
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("connected_component_labeler_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MaxWidth*MaxHeight; i++) lab_mem[i] = 0;
    for (int i = 0; i < MaxLabels; i++) eq_mem[i] = i;
    next_lab = 2;
    col_pos = 0;
    row_pos = 0;
    done_f = 1'b0;
    cnt_f = 0;
    ovf_f = 1'b0;
    reg_w = 256;
    reg_h = 256;
    fw = 0;
    fh = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame (sizes below minimum clamp up), lone center object
    dir_rows.push_back(mk(CmdRead, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk(CmdRead, 255, 16'hFFFF, 1, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 255, 16'hFFFF, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdRead, 0, 4, 1, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 128, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 255, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CmdPixel, 255, 0, 1, 0, 1, 1));
    dir_rows.push_back(mk(CmdRead, 0, 4, 1, 1, 1, 1));
    dir_rows.push_back(mk(CmdRead, 0, 3, 1, 0, 1, 1));
    dir_rows.push_back(mk(CmdRead, 0, 8, 1, 0, 1, 1));
    dir_rows.push_back(mk(CmdRead, 0, 9, 1, 0, 1, 1));
    dir_rows.push_back(mk(CmdRead, 255, 16'hFFFF, 1, 0, 1, 1));
    // next pixel restarts the frame and clears done
    dir_rows.push_back(mk(CmdPixel, 0, 0, 1, 0, 0, 0));

    apb_write(RegImgWidth, 0);
    apb_write(RegImgHeight, 2);
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].pix, dir_rows[i].addr,
                dir_rows[i].typed, dir_rows[i].res);
    // finish that restarted 3x3 frame
    for (int i = 1; i < 9; i++) send_item(CmdPixel, 0, 0, 0, '0);
    in_valid_i <= 1'b0;

    // widest frame with a long output hold, then a tall narrow one
    run_frame(511, 1, 100);
    run_frame(3, 130, -1);
    while (items_sent < 1400) begin
      if ($urandom_range(0, 5) == 0) run_frame($urandom_range(0, 2), $urandom_range(0, 14), -1);
      else run_frame($urandom_range(3, 16), $urandom_range(3, 12), -1);
    end
    quiet = 1'b1;
    run_frame(12, 10, -1);

    wait (label_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d items (%0d reads), %0d frames finished, %0d results checked",
             items_sent, reads_sent, frames_done, results_seen);
    $display("frame sizes from 3x3 to 256x3 and 3x130, with clamped register values");
    if (errors == 0 && label_q.size() == 0) begin
      $display("connected_component_labeler_top verification clean");
    end else begin
      $display("connected_component_labeler_top verification failed");
    end
    $finish;
  end

endmodule
